[src/ips_patch_stream_parser_macros.svh]
// Assertion macros shared by the patch stream parser RTL.
`ifndef IPS_PATCH_STREAM_PARSER_MACROS_SVH
`define IPS_PATCH_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define IPSP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IPSP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ipsp_pkg.sv]
// Types, codes and format constants for the patch stream parser.
`timescale 1ns / 1ps
package ipsp_pkg;

   typedef enum logic [3:0] {
      PH_MAGIC    = 4'd0,
      PH_ADDR     = 4'd1,
      PH_LEN      = 4'd2,
      PH_DATA     = 4'd3,
      PH_RUNCOUNT = 4'd4,
      PH_RUNVALUE = 4'd5,
      PH_IGNORE   = 4'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_WRITE  = 2'd0,
      KIND_OK     = 2'd1,
      KIND_BADMAG = 2'd2,
      KIND_TRUNC  = 2'd3
   } kind_type;

   localparam int unsigned MagicLen    = 5;
   localparam logic [2:0]  AddrLenNarrow = 3'd3;
   localparam logic [2:0]  AddrLenWide   = 3'd4;
   localparam logic [2:0]  LenBytes      = 3'd2;
   localparam logic [31:0] EndNarrow     = 32'h0045_4F46; // "EOF"
   localparam logic [31:0] EndWide       = 32'h4545_4F46; // "EEOF"

   localparam logic [1:0] RegWideFormat = 2'd0;

   // Expected magic byte: "PATCH" for IPS, "IPS32" for IPS32.
   function automatic logic [7:0] magic_byte(input logic wide, input logic [2:0] idx);
      logic [7:0] val;
      val = 8'h00;
      if (wide) begin
         unique case (idx)
            3'd0: val = 8'h49;
            3'd1: val = 8'h50;
            3'd2: val = 8'h53;
            3'd3: val = 8'h33;
            3'd4: val = 8'h32;
            default: val = 8'h00;
         endcase
      end else begin
         unique case (idx)
            3'd0: val = 8'h50;
            3'd1: val = 8'h41;
            3'd2: val = 8'h54;
            3'd3: val = 8'h43;
            3'd4: val = 8'h48;
            default: val = 8'h00;
         endcase
      end
      return val;
   endfunction

endpackage

[src/ips_patch_stream_parser.sv]
// Top level of the IPS / IPS32 patch stream parser.
// A result enters the output register at the edge that accepts its request.
// Throughput: one request per cycle; the only stall is a full output register
// whose result the consumer is not taking (rsp_tready low).
// Reset (synchronous, active high) clears the parse state, the format register
// and the output valid flag; the parser then expects the magic of a new file.
`timescale 1ns / 1ps
module ips_patch_stream_parser (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [31:0] write_address, [39:32] write_value,
                                    // [55:40] fill_count
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ipsp_pkg::*;

`include "ips_patch_stream_parser_macros.svh"

   // Parse state
   phase_type   phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] ofs_ff, ofs_in;
   logic        wide_ff, wide_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   // Per-byte result before the output register
   logic        res_valid;
   kind_type    res_kind;
   logic [31:0] res_addr;
   logic [7:0]  res_val;
   logic [15:0] res_cnt;

   logic        req_acc;
   logic        csr_wr;
   logic [7:0]  b;
   logic [2:0]  idx_inc;
   logic [2:0]  magic_idx;
   logic        magic_ok;
   logic [2:0]  alen;
   logic [31:0] addr_shift;
   logic [31:0] addr_final;
   logic        addr_done;
   logic        end_hit;
   logic [15:0] rem_shift;
   logic [15:0] rem_dec;
   logic        phase_live;

   // ------------------------------------------------------------------
   // Configuration port: one register, wide_format, at byte address 0.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wide_in    = (csr_wr && csr_paddr[2:2] == RegWideFormat[0:0]) ? csr_pwdata[0] : wide_ff;
   assign csr_prdata = (csr_paddr[2:2] == RegWideFormat[0:0]) ? {31'd0, wide_ff} : 32'd0;

   // ------------------------------------------------------------------
   // Handshake: take a request whenever the output register is free or
   // drains in this cycle.
   // ------------------------------------------------------------------
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // Shared byte datapath
   // ------------------------------------------------------------------
   assign b          = req_tdata;
   assign idx_inc    = idx_ff + 3'd1;
   assign magic_idx  = (idx_ff > 3'(MagicLen - 1)) ? 3'd0 : idx_ff;
   assign magic_ok   = (b == magic_byte(wide_ff, magic_idx));
   assign alen       = wide_ff ? AddrLenWide : AddrLenNarrow;
   assign addr_shift = {addr_ff[23:0], b};
   assign addr_done  = (idx_inc >= alen);
   // IPS keeps only 24 address bits
   assign addr_final = wide_ff ? addr_shift : {8'd0, addr_shift[23:0]};
   assign end_hit    = (addr_final == (wide_ff ? EndWide : EndNarrow));
   assign rem_shift  = {rem_ff[7:0], b};
   assign rem_dec    = rem_ff - 16'd1;

   always_comb begin
      unique case (phase_ff)
         PH_MAGIC, PH_ADDR, PH_LEN, PH_DATA, PH_RUNCOUNT, PH_RUNVALUE: phase_live = 1'b1;
         default: phase_live = 1'b0;
      endcase
   end

   // ------------------------------------------------------------------
   // Next state: phase, field index, address, length and data offset.
   // ------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      addr_in  = addr_ff;
      rem_in   = rem_ff;
      ofs_in   = ofs_ff;
      if (req_acc) begin
         unique case (phase_ff)
            PH_MAGIC: begin
               if (!magic_ok) begin
                  phase_in = PH_IGNORE;
               end else if (magic_idx == 3'(MagicLen - 1)) begin
                  phase_in = PH_ADDR;
                  idx_in   = 3'd0;
                  addr_in  = 32'd0;
               end else begin
                  idx_in = magic_idx + 3'd1;
               end
            end
            PH_ADDR: begin
               addr_in = addr_shift;
               idx_in  = idx_inc;
               if (addr_done) begin
                  addr_in = addr_final;
                  if (end_hit) begin
                     phase_in = PH_IGNORE;
                  end else begin
                     phase_in = PH_LEN;
                     idx_in   = 3'd0;
                     rem_in   = 16'd0;
                  end
               end
            end
            PH_LEN: begin
               rem_in = rem_shift;
               idx_in = idx_inc;
               if (idx_inc >= LenBytes) begin
                  idx_in = 3'd0;
                  if (rem_shift == 16'd0) begin
                     phase_in = PH_RUNCOUNT;
                  end else begin
                     phase_in = PH_DATA;
                     ofs_in   = 16'd0;
                  end
               end
            end
            PH_DATA: begin
               ofs_in = ofs_ff + 16'd1;
               rem_in = rem_dec;
               // record done: start the next one
               if (rem_dec == 16'd0) begin
                  phase_in = PH_ADDR;
                  idx_in   = 3'd0;
                  addr_in  = 32'd0;
               end
            end
            PH_RUNCOUNT: begin
               rem_in = rem_shift;
               idx_in = idx_inc;
               if (idx_inc >= LenBytes) begin
                  idx_in   = 3'd0;
                  phase_in = PH_RUNVALUE;
               end
            end
            PH_RUNVALUE: begin
               phase_in = PH_ADDR;
               idx_in   = 3'd0;
               addr_in  = 32'd0;
            end
            default: begin
               // ignore phase and unused codes: drop the byte
            end
         endcase
         // End of file: always go back to expecting a new magic.
         if (req_tlast) begin
            phase_in = PH_MAGIC;
            idx_in   = 3'd0;
            addr_in  = 32'd0;
            rem_in   = 16'd0;
            ofs_in   = 16'd0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result of the current request.
   // ------------------------------------------------------------------
   always_comb begin
      res_valid = 1'b0;
      res_kind  = KIND_WRITE;
      res_addr  = 32'd0;
      res_val   = 8'd0;
      res_cnt   = 16'd0;
      unique case (phase_ff)
         PH_MAGIC: begin
            if (!magic_ok) begin
               res_valid = 1'b1;
               res_kind  = KIND_BADMAG;
            end
         end
         PH_ADDR: begin
            if (addr_done && end_hit) begin
               res_valid = 1'b1;
               res_kind  = KIND_OK;
            end
         end
         PH_DATA: begin
            res_valid = 1'b1;
            res_addr  = addr_ff + {16'd0, ofs_ff};
            res_val   = b;
            res_cnt   = 16'd1;
         end
         PH_RUNVALUE: begin
            // a zero run count gives no fill
            if (rem_ff != 16'd0) begin
               res_valid = 1'b1;
               res_addr  = addr_ff;
               res_val   = b;
               res_cnt   = rem_ff;
            end
         end
         default: begin
         end
      endcase
      // Early end replaces any write that the final byte would give.
      if (req_tlast && phase_live && !(res_valid && res_kind != KIND_WRITE)) begin
         res_valid = 1'b1;
         res_kind  = KIND_TRUNC;
         res_addr  = 32'd0;
         res_val   = 8'd0;
         res_cnt   = 16'd0;
      end
   end

   // ------------------------------------------------------------------
   // Output register: load on an accepted request, clear once taken.
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (req_acc) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = {res_cnt, res_val, res_addr};
            rsp_user_in = res_kind;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         idx_ff       <= 3'd0;
         addr_ff      <= 32'd0;
         rem_ff       <= 16'd0;
         ofs_ff       <= 16'd0;
         wide_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         addr_ff      <= addr_in;
         rem_ff       <= rem_in;
         ofs_ff       <= ofs_in;
         wide_ff      <= wide_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `IPSP_ASSERT_NXT(a_last_restarts, clock, reset, req_acc && req_tlast, phase_ff == PH_MAGIC && idx_ff == 3'd0 && addr_ff == 32'd0, "last byte did not restart the parser")
   `IPSP_ASSERT_NXT(a_ignore_silent, clock, reset, req_acc && phase_ff == PH_IGNORE && !req_tlast, !rsp_valid_ff, "ignored byte produced a result")
   `IPSP_ASSERT_IMP(a_status_clean, clock, reset, rsp_valid_ff && rsp_user_ff != KIND_WRITE, rsp_data_ff == 56'd0, "status result with nonzero payload")
   `IPSP_ASSERT_IMP(a_write_count, clock, reset, rsp_valid_ff && rsp_user_ff == KIND_WRITE, rsp_data_ff[55:40] != 16'd0, "write result with zero count")
   `IPSP_ASSERT_IMP(a_data_len, clock, reset, phase_ff == PH_DATA, rem_ff != 16'd0, "data phase with no bytes left")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the IPS / IPS32 patch stream parser.
`timescale 1ns / 1ps

import ipsp_pkg::*;

localparam logic [39:0] MAGIC_IPS   = "PATCH";
localparam logic [39:0] MAGIC_IPS32 = "IPS32";

typedef struct packed {
   kind_type    kind;
   logic [31:0] addr;
   logic [7:0]  value;
   logic [15:0] count;
} patch_cmd_type;

// Tracks the parser state byte by byte and holds the commands it should emit.
class patch_checker;
   logic          wide;
   phase_type     phase;
   logic [2:0]    idx;
   logic [31:0]   addr;
   logic [15:0]   remaining;
   logic [15:0]   offset;
   patch_cmd_type expected_cmds[$];
   int            mismatches;
   int            parsed_bytes;

   function new();
      wide         = 1'b0;
      mismatches   = 0;
      parsed_bytes = 0;
      clear_parse();
   endfunction

   function void clear_parse();
      phase     = PH_MAGIC;
      idx       = 3'd0;
      addr      = 32'd0;
      remaining = 16'd0;
      offset    = 16'd0;
   endfunction

   function void open_record();
      phase = PH_ADDR;
      idx   = 3'd0;
      addr  = 32'd0;
   endfunction

   function logic [7:0] header_byte(logic [2:0] pos);
      logic [39:0] hdr;
      hdr = wide ? MAGIC_IPS32 : MAGIC_IPS;
      return hdr[8 * (4 - pos) +: 8];
   endfunction

   function int pending();
      return expected_cmds.size();
   endfunction

   task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] %s", $realtime, msg);
   endtask

   // Advance the parse by one accepted request and queue any command it yields.
   function void take_byte(logic [7:0] b, logic last);
      phase_type     entry_phase;
      bit            have;
      bit            status;
      patch_cmd_type cmd;
      logic [2:0]    pos;
      logic [2:0]    alen;
      entry_phase = phase;
      have        = 1'b0;
      status      = 1'b0;
      cmd         = '0;
      if (phase != PH_IGNORE) parsed_bytes++;
      case (phase)
         PH_MAGIC: begin
            pos = (idx > 3'd4) ? 3'd0 : idx;
            if (b != header_byte(pos)) begin
               cmd.kind = KIND_BADMAG;
               have     = 1'b1;
               status   = 1'b1;
               phase    = PH_IGNORE;
            end else if (pos == 3'd4) begin
               open_record();
            end else begin
               idx = pos + 3'd1;
            end
         end
         PH_ADDR: begin
            alen = wide ? AddrLenWide : AddrLenNarrow;
            addr = {addr[23:0], b};
            idx  = idx + 3'd1;
            if (idx >= alen) begin
               if (!wide) addr[31:24] = 8'h00;
               if (addr == (wide ? EndWide : EndNarrow)) begin
                  cmd.kind = KIND_OK;
                  have     = 1'b1;
                  status   = 1'b1;
                  phase    = PH_IGNORE;
               end else begin
                  phase     = PH_LEN;
                  idx       = 3'd0;
                  remaining = 16'd0;
               end
            end
         end
         PH_LEN: begin
            remaining = {remaining[7:0], b};
            idx       = idx + 3'd1;
            if (idx >= LenBytes) begin
               idx = 3'd0;
               if (remaining == 16'd0) begin
                  phase = PH_RUNCOUNT;
               end else begin
                  phase  = PH_DATA;
                  offset = 16'd0;
               end
            end
         end
         PH_DATA: begin
            cmd.kind  = KIND_WRITE;
            cmd.addr  = addr + {16'd0, offset};
            cmd.value = b;
            cmd.count = 16'd1;
            have      = 1'b1;
            offset    = offset + 16'd1;
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) open_record();
         end
         PH_RUNCOUNT: begin
            remaining = {remaining[7:0], b};
            idx       = idx + 3'd1;
            if (idx >= LenBytes) begin
               idx   = 3'd0;
               phase = PH_RUNVALUE;
            end
         end
         PH_RUNVALUE: begin
            // a run with a zero count emits nothing
            if (remaining != 16'd0) begin
               cmd.kind  = KIND_WRITE;
               cmd.addr  = addr;
               cmd.value = b;
               cmd.count = remaining;
               have      = 1'b1;
            end
            open_record();
         end
         default: ;
      endcase
      if (last) begin
         // early end replaces whatever this byte would have produced
         if (!status && entry_phase != PH_IGNORE && entry_phase <= PH_RUNVALUE) begin
            cmd      = '0;
            cmd.kind = KIND_TRUNC;
            have     = 1'b1;
         end
         clear_parse();
      end
      if (have) expected_cmds = {expected_cmds, cmd};
   endfunction

   task check_result(logic [1:0] kind_bits, logic [55:0] data);
      patch_cmd_type want;
      if (expected_cmds.size() == 0) begin
         report($sformatf("unexpected result: kind %0d addr %h value %h count %0d",
                          kind_bits, data[31:0], data[39:32], data[55:40]));
         return;
      end
      want = expected_cmds.pop_front();
      if (kind_bits !== want.kind || data[31:0] !== want.addr ||
          data[39:32] !== want.value || data[55:40] !== want.count)
         report($sformatf("bad result: want %0d/%h/%h/%0d got %0d/%h/%h/%0d",
                          want.kind, want.addr, want.value, want.count,
                          kind_bits, data[31:0], data[39:32], data[55:40]));
   endtask
endclass

module tb_top;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         PHASE_BYTES = 190;
   localparam logic [2:0] FORMAT_ADDR = 3'(RegWideFormat) << 2;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b1;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   patch_checker sb;
   logic [7:0]   file_q[$];
   bit           quiet       = 1'b0;
   int           stall_left  = 0;
   int           cycle_count = 0;

   ips_patch_stream_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hold the result side off in short random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check results first; a request accepted now shows its result later.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
         if (req_tvalid && req_tready) sb.take_byte(req_tdata, req_tlast);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void add_be(logic [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--) file_q = {file_q, v[8 * i +: 8]};
   endfunction

   task automatic push_byte(logic [7:0] b, logic last);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_q.size(); i++) push_byte(file_q[i], i == file_q.size() - 1);
   endtask

   // Drop the request valid and wait out every pending result.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      // let the monitor note the request taken at the last edge
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_format(logic wide);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= FORMAT_ADDR;
      csr_pwdata  <= {31'($urandom_range(0, 32'h7FFF_FFFF)), wide};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.wide     = wide;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      // read back
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {31'd0, wide})
         sb.report($sformatf("format register reads %h, want %0d", csr_prdata, wide));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Build one patch file: mostly well formed, some cut short, corrupted or noise.
   task automatic make_file(logic wide);
      int          pick;
      int          len;
      int          cut;
      int          pos;
      logic [31:0] a;
      logic [15:0] cnt;
      file_q.delete();
      pick = $urandom_range(0, 99);
      if (pick >= 93) begin
         repeat ($urandom_range(1, 6)) file_q = {file_q, 8'($urandom_range(0, 255))};
         return;
      end
      add_be(64'(wide ? MAGIC_IPS32 : MAGIC_IPS), 5);
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 5))
            0:       a = 32'd0;
            1:       a = 32'hFFFF_FFFF;
            2:       a = wide ? EndNarrow : (EndNarrow ^ 32'd1);
            default: a = $urandom;
         endcase
         if (!wide && a[23:0] == EndNarrow[23:0]) a = a ^ 32'd1;
         if (wide && a == EndWide) a = a ^ 32'd1;
         add_be(64'(a), wide ? 4 : 3);
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
               0:       cnt = 16'd0;
               1:       cnt = 16'd1;
               2:       cnt = 16'hFFFF;
               default: cnt = 16'($urandom);
            endcase
            add_be(64'd0, 2);
            add_be(64'(cnt), 2);
            add_be(64'($urandom_range(0, 255)), 1);
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            add_be(64'(len), 2);
            repeat (len) file_q = {file_q, 8'($urandom_range(0, 255))};
         end
      end
      add_be(64'(wide ? EndWide : EndNarrow), wide ? 4 : 3);
      repeat ($urandom_range(0, 2)) file_q = {file_q, 8'($urandom_range(0, 255))};
      if (pick >= 70 && pick < 85) begin
         cut = $urandom_range(1, file_q.size() - 1);
         while (file_q.size() > cut) void'(file_q.pop_back());
      end else if (pick >= 85) begin
         pos         = $urandom_range(0, 4);
         file_q[pos] = file_q[pos] ^ 8'($urandom_range(1, 255));
      end
   endtask

   initial begin
      int   goal;
      logic wide;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: data write, end marker with a trailing byte, on the reset format.
      add_be(64'(MAGIC_IPS), 5);
      add_be(64'd0, 3);
      add_be(64'd1, 2);
      add_be(64'h00, 1);
      add_be(64'(EndNarrow), 3);
      add_be(64'hFF, 1);
      send_file();
      // bad magic on the first byte
      file_q = '{8'hFF};
      send_file();
      // file ends inside the magic
      file_q = '{8'h50};
      send_file();
      // wide magic, then the file ends on a record boundary
      set_format(1'b1);
      file_q.delete();
      add_be(64'(MAGIC_IPS32), 5);
      send_file();

      // Random phases; each change of format drains the parser first.
      for (int p = 0; p < 6; p++) begin
         wide = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
         set_format(wide);
         quiet = (p == 5);
         goal  = sb.parsed_bytes + PHASE_BYTES;
         while (sb.parsed_bytes < goal) begin
            make_file(wide);
            send_file();
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
